>>> rtl/geg_pkg.sv
// ----------------------------------------------------------------------------
// geg_pkg
// Types and constants shared by the gesture event gate.
// ----------------------------------------------------------------------------
`default_nettype none

package geg_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_STABLE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REARM    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REFRACT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ABORT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLDOFF  = 3'd4;

  localparam logic [CFG_DAT_W-1:0] RST_STABLE  = 16'd3;
  localparam logic [CFG_DAT_W-1:0] RST_REARM   = 16'd2;
  localparam logic [CFG_DAT_W-1:0] RST_REFRACT = 16'd5;
  localparam logic [CFG_DAT_W-1:0] RST_ABORT   = 16'd2;
  localparam logic [CFG_DAT_W-1:0] RST_HOLDOFF = 16'd1;

  localparam logic [2:0] CODE_ABORT = 3'd3;

  localparam logic [1:0] CLS_REST    = 2'd0;
  localparam logic [1:0] CLS_NEXT    = 2'd1;
  localparam logic [1:0] CLS_CONFIRM = 2'd2;
  localparam logic [1:0] CLS_ABORT   = 2'd3;

  typedef struct packed {
    logic [2:0] class_code;
    logic       window_valid;
  } in_item_t;

  typedef struct packed {
    logic       fired;
    logic [1:0] event_class;
  } out_item_t;

  typedef struct packed {
    logic       clr;
    logic [1:0] cls;
  } cmd_t;

endpackage

`default_nettype wire

>>> rtl/geg_front.sv
// ----------------------------------------------------------------------------
// geg_front
// Accepts window decisions and classifies them into gate commands.
// ----------------------------------------------------------------------------
`default_nettype none

module geg_front (
  input  wire              in_valid,
  input  geg_pkg::in_item_t in_data,
  output logic             in_stall,
  input  wire              q_full,
  output logic             push,
  output geg_pkg::cmd_t    push_cmd
);
  import geg_pkg::*;

  assign in_stall = q_full;
  assign push     = in_valid & ~q_full;

  always_comb begin
    push_cmd.clr = ~in_data.window_valid || (in_data.class_code > CODE_ABORT);
    push_cmd.cls = in_data.class_code[1:0];
  end

endmodule

`default_nettype wire

>>> rtl/geg_queue.sv
// ----------------------------------------------------------------------------
// geg_queue
// Two-entry command queue between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module geg_queue (
  input  wire           clk,
  input  wire           rst_n,
  input  wire           push,
  input  geg_pkg::cmd_t push_cmd,
  output logic          full,
  output logic          q_valid,
  output geg_pkg::cmd_t q_cmd,
  input  wire           pop
);
  import geg_pkg::*;

  cmd_t       ent_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_pop;

  assign full    = (cnt_r == 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign q_cmd   = ent_r[rd_ptr_r];
  assign do_pop  = pop & q_valid;

  always_comb begin
    wr_ptr_nxt = push   ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

>>> rtl/geg_back.sv
// ----------------------------------------------------------------------------
// geg_back
// Gate state, settings registers and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module geg_back #(
  parameter int COUNT_WIDTH = 16
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              cfg_valid,
  input  wire  [geg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire  [geg_pkg::CFG_DAT_W-1:0]    cfg_data,
  input  wire                              q_valid,
  input  geg_pkg::cmd_t                    q_cmd,
  output logic                             pop,
  output logic                             out_valid,
  input  wire                              out_stall,
  output geg_pkg::out_item_t               out_data
);
  import geg_pkg::*;

  localparam int CW = COUNT_WIDTH;
  localparam int WW = (COUNT_WIDTH > CFG_DAT_W) ? COUNT_WIDTH : CFG_DAT_W;
  localparam logic [CW-1:0] CMAX = {CW{1'b1}};

  function automatic logic [CW-1:0] sat_cfg(input logic [CFG_DAT_W-1:0] v);
    logic [WW-1:0] w;
    w = WW'(v);
    if (w > WW'(CMAX)) return CMAX;
    return w[CW-1:0];
  endfunction

  function automatic logic [CW-1:0] bump(input logic [CW-1:0] v);
    return (v != CMAX) ? v + CW'(1) : v;
  endfunction

  logic [CFG_DAT_W-1:0] stable_r, rearm_r, refract_r, abort_r, holdoff_cfg_r;

  logic [CW-1:0] grun_r, grun_nxt;
  logic [CW-1:0] rrun_r, rrun_nxt;
  logic [CW-1:0] arun_r, arun_nxt;
  logic [CW-1:0] refr_r, refr_nxt;
  logic [CW-1:0] hold_r, hold_nxt;
  logic [1:0]    pend_r, pend_nxt;
  logic          pend_v_r, pend_v_nxt;
  logic          armed_r, armed_nxt;
  logic          latch_r, latch_nxt;
  logic          rest_r, rest_nxt;

  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_r, out_nxt;

  logic [CW-1:0] refr_dec, hold_cur, cnt_tmp;

  assign pop       = q_valid & (~out_valid_r | ~out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stable_r      <= RST_STABLE;
      rearm_r       <= RST_REARM;
      refract_r     <= RST_REFRACT;
      abort_r       <= RST_ABORT;
      holdoff_cfg_r <= RST_HOLDOFF;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_STABLE:  stable_r      <= cfg_data;
        CFG_REARM:   rearm_r       <= cfg_data;
        CFG_REFRACT: refract_r     <= cfg_data;
        CFG_ABORT:   abort_r       <= cfg_data;
        CFG_HOLDOFF: holdoff_cfg_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    grun_nxt   = grun_r;
    rrun_nxt   = rrun_r;
    arun_nxt   = arun_r;
    refr_nxt   = refr_r;
    hold_nxt   = hold_r;
    pend_nxt   = pend_r;
    pend_v_nxt = pend_v_r;
    armed_nxt  = armed_r;
    latch_nxt  = latch_r;
    rest_nxt   = rest_r;
    out_nxt    = '0;
    cnt_tmp    = '0;
    refr_dec   = (refr_r != '0) ? refr_r - CW'(1) : refr_r;
    hold_cur   = rest_r ? sat_cfg(holdoff_cfg_r) : hold_r;

    if (q_cmd.clr) begin
      grun_nxt   = '0;
      rrun_nxt   = '0;
      arun_nxt   = '0;
      refr_nxt   = '0;
      hold_nxt   = '0;
      pend_nxt   = CLS_REST;
      pend_v_nxt = 1'b0;
      armed_nxt  = 1'b0;
      latch_nxt  = 1'b0;
      rest_nxt   = 1'b1;
    end else if (q_cmd.cls == CLS_REST) begin
      refr_nxt   = refr_dec;
      rest_nxt   = 1'b1;
      hold_nxt   = '0;
      pend_v_nxt = 1'b0;
      grun_nxt   = '0;
      arun_nxt   = '0;
      rrun_nxt   = bump(rrun_r);
      if (rrun_nxt >= sat_cfg(rearm_r) && refr_dec == '0) begin
        armed_nxt = 1'b1;
        latch_nxt = 1'b0;
      end
    end else begin
      refr_nxt = refr_dec;
      rrun_nxt = '0;
      rest_nxt = 1'b0;
      if (hold_cur != '0) begin
        hold_nxt   = hold_cur - CW'(1);
        pend_v_nxt = 1'b0;
        grun_nxt   = '0;
        arun_nxt   = '0;
      end else begin
        hold_nxt = '0;
        if (q_cmd.cls == CLS_ABORT) begin
          pend_v_nxt = 1'b0;
          grun_nxt   = '0;
          arun_nxt   = bump(arun_r);
          if (arun_nxt >= sat_cfg(abort_r) && !latch_r) begin
            latch_nxt         = 1'b1;
            armed_nxt         = 1'b0;
            refr_nxt          = sat_cfg(refract_r);
            out_nxt.fired       = 1'b1;
            out_nxt.event_class = CLS_ABORT;
          end
        end else begin
          arun_nxt = '0;
          if (!armed_r || refr_dec != '0) begin
            pend_v_nxt = 1'b0;
            grun_nxt   = '0;
          end else begin
            if (pend_v_r && q_cmd.cls == pend_r) begin
              cnt_tmp = bump(grun_r);
            end else begin
              cnt_tmp = CW'(1);
            end
            pend_nxt   = q_cmd.cls;
            pend_v_nxt = 1'b1;
            grun_nxt   = cnt_tmp;
            if (cnt_tmp >= sat_cfg(stable_r)) begin
              out_nxt.fired       = 1'b1;
              out_nxt.event_class = q_cmd.cls;
              armed_nxt  = 1'b0;
              pend_v_nxt = 1'b0;
              grun_nxt   = '0;
              refr_nxt   = sat_cfg(refract_r);
            end
          end
        end
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grun_r      <= '0;
      rrun_r      <= '0;
      arun_r      <= '0;
      refr_r      <= '0;
      hold_r      <= '0;
      pend_r      <= CLS_REST;
      pend_v_r    <= 1'b0;
      armed_r     <= 1'b0;
      latch_r     <= 1'b0;
      rest_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (pop) begin
        grun_r   <= grun_nxt;
        rrun_r   <= rrun_nxt;
        arun_r   <= arun_nxt;
        refr_r   <= refr_nxt;
        hold_r   <= hold_nxt;
        pend_r   <= pend_nxt;
        pend_v_r <= pend_v_nxt;
        armed_r  <= armed_nxt;
        latch_r  <= latch_nxt;
        rest_r   <= rest_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_r <= out_nxt;
    end
  end

  a_fired_class: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.fired == (out_r.event_class != CLS_REST)))
    else $error("fired flag and event class disagree");

  a_clear_state: assert property (@(posedge clk) disable iff (!rst_n)
    pop && q_cmd.clr |=> !armed_r && !latch_r && rest_r && !pend_v_r)
    else $error("clear command left gate state behind");

  a_abort_latch: assert property (@(posedge clk) disable iff (!rst_n)
    pop && out_nxt.fired && out_nxt.event_class == CLS_ABORT |=> latch_r && !armed_r)
    else $error("abort event did not latch and disarm");

  a_event_disarm: assert property (@(posedge clk) disable iff (!rst_n)
    pop && out_nxt.fired |=> !armed_r && !pend_v_r && grun_r == '0)
    else $error("gate still armed after an event");

endmodule

`default_nettype wire

>>> rtl/gesture_event_gate.sv
// ----------------------------------------------------------------------------
// gesture_event_gate
// Turns per-window classifier decisions into single gesture events.
//
//   channel | ports                              | direction
//   --------+------------------------------------+----------
//   in      | in_valid, in_stall, in_data        | window decision in
//   out     | out_valid, out_stall, out_data     | one result per window out
//   cfg     | cfg_valid, cfg_ready, cfg_index,   | settings register write
//           | cfg_data                           |
//
// One window per clock while out_stall is low. A command is registered in
// the queue, then in the result register. The queue holds two commands, so
// the input stalls only once both the queue and the result register are full.
// Synchronous active-low reset restores the default settings and gate state.
// cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module gesture_event_gate #(
  parameter int COUNT_WIDTH = 16
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_valid,
  output logic                           in_stall,
  input  geg_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  wire                            out_stall,
  output geg_pkg::out_item_t             out_data,
  input  wire                            cfg_valid,
  output logic                           cfg_ready,
  input  wire  [geg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire  [geg_pkg::CFG_DAT_W-1:0]  cfg_data
);
  import geg_pkg::*;

  logic q_full, push, q_valid, pop;
  cmd_t push_cmd, q_cmd;

  assign cfg_ready = 1'b1;

  geg_front u_front (
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  geg_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .pop      (pop)
  );

  geg_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
